// ===== sv/pps_pkg.sv =====
// polyline path stepper: shared types, widths and codes
`default_nettype none

package pps_pkg;

  localparam int PLEN_W     = 7;
  localparam int IDX_W      = 6;
  localparam int COORD_W    = 16;
  localparam int STEP_W     = 12;
  localparam int LEN_W      = 9;
  localparam int SQ_W       = 33;
  localparam int RAD_W      = 40;
  localparam int ROOT_W     = 20;
  localparam int FRAC_W     = 8;
  localparam int DVD_W      = 28;
  localparam int REM_W      = 23;
  localparam int CNT_W      = 5;
  localparam int SQRT_ITERS = 20;
  localparam int DIV_ITERS  = 28;

  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_LOAD = 1'b1;

  typedef struct packed {
    logic                      action;
    logic [IDX_W-1:0]          load_index;
    logic signed [COORD_W-1:0] load_x;
    logic signed [COORD_W-1:0] load_y;
  } pps_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] marker_x;
    logic signed [COORD_W-1:0] marker_y;
    logic [IDX_W-1:0]          segment_now;
    logic [STEP_W-1:0]         step_now;
    logic                      finished;
  } pps_result_t;

  typedef struct packed {
    logic              go;
    logic              is_div;
    logic [RAD_W-1:0]  arg;
    logic [STEP_W-1:0] divisor;
  } pps_iter_cmd_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] result;
  } pps_iter_rsp_t;

endpackage

`default_nettype wire

// ===== sv/pps_iter.sv =====
// iterative square root and divider on one shared subtractor
`default_nettype none

module pps_iter (
  input  logic                   clk,
  input  logic                   rst,
  input  pps_pkg::pps_iter_cmd_t cmd,
  output pps_pkg::pps_iter_rsp_t rsp
);
  import pps_pkg::*;

  logic              running;
  logic              done_q;
  logic              is_div;
  logic [CNT_W-1:0]  cnt;
  logic [RAD_W-1:0]  arg;
  logic [REM_W-1:0]  rem;
  logic [DVD_W-1:0]  quo;
  logic [STEP_W-1:0] dvs;

  logic [REM_W-1:0]  rem_t;
  logic [REM_W-1:0]  trial;
  logic [REM_W:0]    diff;
  logic              ge;

  // shared trial subtract
  always_comb begin
    if (is_div) begin
      rem_t = {rem[REM_W-2:0], arg[RAD_W-1]};
      trial = REM_W'(dvs);
    end else begin
      rem_t = {rem[REM_W-3:0], arg[RAD_W-1 -: 2]};
      trial = REM_W'({quo[ROOT_W-1:0], 2'b01});
    end
    diff = {1'b0, rem_t} - {1'b0, trial};
    ge   = ~diff[REM_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (cmd.go) begin
        running <= 1'b1;
        is_div  <= cmd.is_div;
        arg     <= cmd.arg;
        dvs     <= cmd.divisor;
        rem     <= '0;
        quo     <= '0;
        cnt     <= cmd.is_div ? CNT_W'(DIV_ITERS - 1) : CNT_W'(SQRT_ITERS - 1);
      end else if (running) begin
        rem <= ge ? diff[REM_W-1:0] : rem_t;
        quo <= {quo[DVD_W-2:0], ge};
        arg <= is_div ? (arg << 1) : (arg << 2);
        cnt <= cnt - CNT_W'(1);
        if (cnt == '0) begin
          running <= 1'b0;
          done_q  <= 1'b1;
        end
      end
    end
  end

  assign rsp.done   = done_q;
  assign rsp.result = quo;

endmodule

`default_nettype wire

// ===== sv/polyline_path_stepper.sv =====
// polyline path stepper: waypoint store, sequencer and shared multiplier
// a load, or a tick with no segment ahead, gives its done strobe in the next cycle
// a moving tick reads two waypoints, squares dx and dy on the shared multiplier, then takes a
// square root of 20 result bits and two divides of 28 quotient bits that share one subtractor
// a new word is taken in the done cycle; busy holds off words during a moving tick, else a load every cycle
// synchronous reset clears marker, segment, step count and path length; waypoints are not cleared
`default_nettype none

module polyline_path_stepper #(
  parameter int MAX_WAYPOINTS = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wen,
  input  logic [pps_pkg::PLEN_W-1:0]   cfg_wdata,
  input  logic                         start,
  output logic                         busy,
  input  pps_pkg::pps_item_t           item,
  output logic                         done,
  output pps_pkg::pps_result_t         result
);
  import pps_pkg::*;

  localparam int             AW   = $clog2(MAX_WAYPOINTS);
  localparam logic [LEN_W-1:0] MAXW = LEN_W'(MAX_WAYPOINTS);

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } pps_point_t;

  typedef enum logic [4:0] {
    S_IDLE, S_OUT, S_RDA, S_RDB, S_DIF, S_MXX, S_MYY, S_ADD, S_SCL, S_SQW,
    S_KC, S_MKX, S_DVX, S_DWX, S_MKY, S_DVY, S_DWY, S_UPD
  } state_t;

  state_t state;

  pps_point_t mem [MAX_WAYPOINTS];
  pps_point_t rd_q;
  logic [AW-1:0] rd_addr;

  logic [PLEN_W-1:0]  path_length;
  logic [PLEN_W-1:0]  seg;
  logic [STEP_W-1:0]  step_count;
  logic [COORD_W-1:0] position_x;
  logic [COORD_W-1:0] position_y;
  logic [COORD_W-1:0] x0;
  logic [COORD_W-1:0] y0;
  logic signed [COORD_W:0] dx;
  logic signed [COORD_W:0] dy;
  logic signed [35:0] prod;
  logic [SQ_W-1:0]    sq;
  logic [STEP_W-1:0]  steps;
  logic [STEP_W-1:0]  k;
  logic               neg;

  logic [LEN_W-1:0]   eff_len;
  logic               has_next;
  logic               accept;
  logic               slot_ok;
  logic signed [17:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [35:0] mul_p;
  logic [35:0]        mag;
  logic [RAD_W-1:0]   sq_x100;
  logic [STEP_W:0]    kinc;
  logic [STEP_W-1:0]  root_int;
  logic [17:0]        qs;
  logic [17:0]        qsig;
  logic [COORD_W-1:0] base;
  logic [17:0]        pos_sum;

  pps_iter_cmd_t icmd;
  pps_iter_rsp_t irsp;

  pps_iter u_iter (
    .clk (clk),
    .rst (rst),
    .cmd (icmd),
    .rsp (irsp)
  );

  assign eff_len  = (LEN_W'(path_length) > MAXW) ? MAXW : LEN_W'(path_length);
  assign has_next = (LEN_W'(seg) + LEN_W'(1)) < eff_len;
  assign busy     = !(state == S_IDLE || state == S_OUT);
  assign accept   = start && !busy;
  assign slot_ok  = LEN_W'(item.load_index) < MAXW;
  assign done     = (state == S_OUT);

  // waypoint store
  assign rd_addr = (state == S_RDB) ? AW'(seg + PLEN_W'(1)) : AW'(seg);

  always_ff @(posedge clk) begin
    if (accept && item.action == ACT_LOAD && slot_ok) begin
      mem[AW'(item.load_index)] <= {item.load_x, item.load_y};
    end
    rd_q <= mem[rd_addr];
  end

  // shared multiplier
  always_comb begin
    mul_a = (state == S_MYY || state == S_MKY) ? {dy[COORD_W], dy} : {dx[COORD_W], dx};
    case (state)
      S_MXX:   mul_b = {dx[COORD_W], dx};
      S_MYY:   mul_b = {dy[COORD_W], dy};
      default: mul_b = {6'b0, k};
    endcase
    mul_p = mul_a * mul_b;
  end

  always_comb begin
    mag      = prod[35] ? 36'(-prod) : 36'(prod);
    sq_x100  = (RAD_W'(sq) << 6) + (RAD_W'(sq) << 5) + (RAD_W'(sq) << 2);
    kinc     = {1'b0, step_count} + (STEP_W+1)'(1);
    root_int = irsp.result[ROOT_W-1:FRAC_W];
    qs       = {1'b0, irsp.result[16:0]};
    qsig     = neg ? 18'(-qs) : qs;
    base     = (state == S_DWY) ? y0 : x0;
    pos_sum  = {{2{base[COORD_W-1]}}, base} + qsig;

    icmd.go      = (state == S_SCL || state == S_DVX || state == S_DVY);
    icmd.is_div  = (state != S_SCL);
    icmd.arg     = (state == S_SCL) ? sq_x100 : {mag[DVD_W-1:0], 12'b0};
    icmd.divisor = steps;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      path_length <= '0;
      seg         <= '0;
      step_count  <= '0;
      position_x  <= '0;
      position_y  <= '0;
    end else begin
      if (cfg_wen) begin
        path_length <= cfg_wdata;
      end
      unique case (state)
        S_IDLE, S_OUT: begin
          if (start) begin
            if (item.action == ACT_TICK && has_next) begin
              state <= S_RDA;
            end else begin
              state <= S_OUT;
            end
          end else begin
            state <= S_IDLE;
          end
        end
        S_RDA: state <= S_RDB;
        S_RDB: begin
          x0    <= rd_q.x;
          y0    <= rd_q.y;
          state <= S_DIF;
        end
        S_DIF: begin
          dx    <= {rd_q.x[COORD_W-1], rd_q.x} - {x0[COORD_W-1], x0};
          dy    <= {rd_q.y[COORD_W-1], rd_q.y} - {y0[COORD_W-1], y0};
          state <= S_MXX;
        end
        S_MXX: begin
          prod  <= mul_p;
          state <= S_MYY;
        end
        S_MYY: begin
          sq    <= prod[SQ_W-1:0];
          prod  <= mul_p;
          state <= S_ADD;
        end
        S_ADD: begin
          sq    <= sq + prod[SQ_W-1:0];
          state <= S_SCL;
        end
        S_SCL: state <= S_SQW;
        S_SQW: begin
          if (irsp.done) begin
            steps <= (root_int == '0) ? STEP_W'(1) : root_int;
            state <= S_KC;
          end
        end
        S_KC: begin
          k     <= (kinc > {1'b0, steps}) ? steps : kinc[STEP_W-1:0];
          state <= S_MKX;
        end
        S_MKX: begin
          prod  <= mul_p;
          state <= S_DVX;
        end
        S_DVX: begin
          neg   <= prod[35];
          state <= S_DWX;
        end
        S_DWX: begin
          if (irsp.done) begin
            position_x <= pos_sum[COORD_W-1:0];
            state      <= S_MKY;
          end
        end
        S_MKY: begin
          prod  <= mul_p;
          state <= S_DVY;
        end
        S_DVY: begin
          neg   <= prod[35];
          state <= S_DWY;
        end
        S_DWY: begin
          if (irsp.done) begin
            position_y <= pos_sum[COORD_W-1:0];
            state      <= S_UPD;
          end
        end
        S_UPD: begin
          if (k == steps) begin
            seg        <= seg + PLEN_W'(1);
            step_count <= '0;
          end else begin
            step_count <= k;
          end
          state <= S_OUT;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign result.marker_x    = position_x;
  assign result.marker_y    = position_y;
  assign result.segment_now = seg[IDX_W-1:0];
  assign result.step_now    = step_count;
  assign result.finished    = !has_next;

  a_seg_monotonic : assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> seg >= $past(seg))
    else $error("segment index went backwards");

  a_step_below_steps : assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && $past(state) == S_UPD) |-> step_count < steps)
    else $error("step count reached segment length without advancing");

  a_iter_done_waited : assert property (@(posedge clk) disable iff (rst)
    irsp.done |-> (state == S_SQW || state == S_DWX || state == S_DWY))
    else $error("iterative unit finished while not awaited");

  a_tick_goes_busy : assert property (@(posedge clk) disable iff (rst)
    (accept && item.action == ACT_TICK && has_next) |=> busy)
    else $error("moving tick did not raise busy");

endmodule

`default_nettype wire
